// ----- rtl/rsd_pkg.sv -----
// Shared types, stage layout and per-stage datapath functions for the stick deadzone core.
package rsd_pkg;

   localparam int unsigned PCT_MAX    = 30;
   localparam int unsigned PCT_W      = 5;
   localparam int unsigned CENTER     = 128;
   localparam int unsigned POS_LIMIT  = 127;
   localparam int unsigned NEG_LIMIT  = 128;

   // pipeline layout
   localparam int unsigned SQ_FIRST   = 1;
   localparam int unsigned SQ_STEPS   = 8;
   localparam int unsigned MAG_STG    = SQ_FIRST + SQ_STEPS;
   localparam int unsigned D1_FIRST   = MAG_STG + 1;
   localparam int unsigned D1_STEPS   = 15;
   localparam int unsigned MAX_STG    = D1_FIRST + D1_STEPS;
   localparam int unsigned MUL2_STG   = MAX_STG + 1;
   localparam int unsigned D2_FIRST   = MUL2_STG + 1;
   localparam int unsigned D2_STEPS   = 23;
   localparam int unsigned MUL3_STG   = D2_FIRST + D2_STEPS;
   localparam int unsigned D3_FIRST   = MUL3_STG + 1;
   localparam int unsigned D3_STEPS   = 23;
   localparam int unsigned OUT_STG    = D3_FIRST + D3_STEPS;
   localparam int unsigned STAGES     = OUT_STG + 1;

   typedef struct packed {
      logic [7:0] x_raw;
      logic [7:0] y_raw;
   } req_type;

   typedef struct packed {
      logic [7:0] x_out;
      logic [7:0] y_out;
   } rsp_type;

   // restoring divider lane: n shifts numerator out and quotient in
   typedef struct packed {
      logic [22:0] n;
      logic [14:0] r;
      logic [14:0] d;
   } lane_type;

   typedef struct packed {
      logic              byp;
      logic [7:0]        x_raw;
      logic [7:0]        y_raw;
      logic signed [8:0] dx;
      logic signed [8:0] dy;
      logic [5:0]        dz;
      logic [15:0]       sv;
      logic [15:0]       sr;
      logic [7:0]        mag;
      logic              dead;
      logic [14:0]       maxm;
      lane_type          la;
      lane_type          lb;
   } stage_type;

   typedef logic [5:0] dz_table_type [32];

   function automatic dz_table_type build_dz();
      dz_table_type t;
      for (int p = 0; p < 32; p++) begin
         t[p] = 6'((p * CENTER + 50) / 100);
      end
      return t;
   endfunction

   localparam dz_table_type DZ_TABLE = build_dz();

   function automatic logic [7:0] abs9(input logic signed [8:0] v);
      logic [8:0] a;
      a = v[8] ? 9'(-v) : 9'(v);
      return a[7:0];
   endfunction

   function automatic lane_type div_step(input lane_type l);
      lane_type   o;
      logic [15:0] t;
      logic        q;
      t = {l.r, l.n[22]};
      q = 1'b0;
      if (t >= {1'b0, l.d}) begin
         t = t - {1'b0, l.d};
         q = 1'b1;
      end
      o.r = t[14:0];
      o.n = {l.n[21:0], q};
      o.d = l.d;
      return o;
   endfunction

   function automatic logic [7:0] axis_out(input logic signed [8:0] d, input logic [22:0] q);
      logic [7:0] m;
      if (d[8]) begin
         m = (q > 23'(NEG_LIMIT)) ? 8'(NEG_LIMIT) : q[7:0];
         return 8'(9'(CENTER) - {1'b0, m});
      end else begin
         m = (q > 23'(POS_LIMIT)) ? 8'(POS_LIMIT) : q[7:0];
         return 8'(9'(CENTER) + {1'b0, m});
      end
   endfunction

   // one pipeline stage; k is a constant per instance
   function automatic stage_type stage_step(input stage_type s, input int unsigned k);
      stage_type   o;
      logic [15:0] b;
      logic [16:0] sum;
      logic [7:0]  ax;
      logic [7:0]  ay;
      logic [14:0] qa;
      logic [14:0] qb;
      logic [14:0] mm;
      logic [7:0]  diff;
      logic [14:0] omag;
      o  = s;
      ax = abs9(s.dx);
      ay = abs9(s.dy);
      if (k >= SQ_FIRST && k < MAG_STG) begin
         b   = 16'(1) << (2 * (MAG_STG - 1 - k));
         sum = {1'b0, s.sr} + {1'b0, b};
         if ({1'b0, s.sv} >= sum) begin
            o.sv = s.sv - sum[15:0];
            o.sr = (s.sr >> 1) + b;
         end else begin
            o.sr = s.sr >> 1;
         end
      end else if (k == MAG_STG) begin
         o.mag  = s.sr[7:0];
         o.la.n = {15'(s.sr[7:0] * (s.dx[8] ? 8'(NEG_LIMIT) : 8'(POS_LIMIT))), 8'd0};
         o.la.r = '0;
         o.la.d = 15'(ax);
         o.lb.n = {15'(s.sr[7:0] * (s.dy[8] ? 8'(NEG_LIMIT) : 8'(POS_LIMIT))), 8'd0};
         o.lb.r = '0;
         o.lb.d = 15'(ay);
      end else if (k >= D1_FIRST && k < MAX_STG) begin
         o.la = div_step(s.la);
         o.lb = div_step(s.lb);
      end else if (k == MAX_STG) begin
         qa = s.la.n[14:0];
         qb = s.lb.n[14:0];
         if (ax == 8'd0)       mm = qb;
         else if (ay == 8'd0)  mm = qa;
         else                  mm = (qb < qa) ? qb : qa;
         o.maxm = mm;
         o.dead = (s.mag == 8'd0) || ({2'b0, s.mag} <= {4'b0, s.dz})
                  || (mm <= 15'(s.dz));
      end else if (k == MUL2_STG) begin
         diff   = s.mag - 8'(s.dz);
         o.la.n = 23'(diff * s.maxm);
         o.la.r = '0;
         o.la.d = s.maxm - 15'(s.dz);
      end else if (k >= D2_FIRST && k < MUL3_STG) begin
         o.la = div_step(s.la);
      end else if (k == MUL3_STG) begin
         omag   = s.la.n[14:0];
         o.la.n = 23'(ax * omag) + 23'(s.mag >> 1);
         o.la.r = '0;
         o.la.d = 15'(s.mag);
         o.lb.n = 23'(ay * omag) + 23'(s.mag >> 1);
         o.lb.r = '0;
         o.lb.d = 15'(s.mag);
      end else if (k >= D3_FIRST && k < OUT_STG) begin
         o.la = div_step(s.la);
         o.lb = div_step(s.lb);
      end else if (k == OUT_STG) begin
         if (s.byp) begin
            o.x_raw = s.x_raw;
            o.y_raw = s.y_raw;
         end else if (s.dead) begin
            o.x_raw = 8'(CENTER);
            o.y_raw = 8'(CENTER);
         end else begin
            o.x_raw = axis_out(s.dx, s.la.n);
            o.y_raw = axis_out(s.dy, s.lb.n);
         end
      end
      return o;
   endfunction

endpackage

// ----- rtl/radial_stick_deadzone_core.sv -----
// Radial scaled deadzone for one analog stick: top level, fully pipelined datapath.
// Takes one stick word per cycle while rsp_ready is high and returns one word per
// input, in order. The pipeline is an input stage, an 8-step square root, three
// bit-per-stage restoring dividers (15, 23 and 23 steps), a few multiply and select
// stages and an output stage, 75 registers in all. Each stage holds its word until
// the next stage is free, so bubbles are absorbed and a stall loses nothing.
// req_ready follows rsp_ready and the fill of the pipeline combinationally. The
// deadzone percent is written on the csr_ port (always ready, 31 saturates to 30) and
// is sampled as a word enters, so change it only while the block is idle.
module radial_stick_deadzone_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  rsd_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsd_pkg::rsp_type           rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [rsd_pkg::PCT_W-1:0]  csr_data
);

   localparam int unsigned N = rsd_pkg::STAGES;

   logic [rsd_pkg::PCT_W-1:0] pct_ff;
   logic [rsd_pkg::PCT_W-1:0] pct_in;
   logic [N-1:0]       valid_ff;
   logic [N:0]         advance;
   rsd_pkg::stage_type stage_ff [N];
   rsd_pkg::stage_type stage_in [N];

   assign csr_ready = 1'b1;
   assign pct_in    = (csr_data > rsd_pkg::PCT_W'(rsd_pkg::PCT_MAX))
                      ? rsd_pkg::PCT_W'(rsd_pkg::PCT_MAX) : csr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         pct_ff <= '0;
      end else if (csr_valid) begin
         pct_ff <= pct_in;
      end
   end

   // a stage loads when it is empty or its word moves on
   assign advance[N] = rsp_ready;
   for (genvar k = 0; k < N; k++) begin : g_adv
      assign advance[k] = !valid_ff[k] || advance[k+1];
   end
   assign req_ready = advance[0];

   always_comb begin
      logic [7:0] ax;
      logic [7:0] ay;
      stage_in[0]       = '0;
      stage_in[0].byp   = (pct_ff == '0);
      stage_in[0].x_raw = req_data.x_raw;
      stage_in[0].y_raw = req_data.y_raw;
      stage_in[0].dx    = 9'(signed'({1'b0, req_data.x_raw}) - 9'sd128);
      stage_in[0].dy    = 9'(signed'({1'b0, req_data.y_raw}) - 9'sd128);
      stage_in[0].dz    = rsd_pkg::DZ_TABLE[pct_ff];
      ax = rsd_pkg::abs9(stage_in[0].dx);
      ay = rsd_pkg::abs9(stage_in[0].dy);
      stage_in[0].sv    = 16'(ax * ax) + 16'(ay * ay);
   end

   for (genvar k = 1; k < N; k++) begin : g_stage
      always_comb stage_in[k] = rsd_pkg::stage_step(stage_ff[k-1], k);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (advance[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int k = 1; k < N; k++) begin
            if (advance[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < N; k++) begin
         if (advance[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign rsp_valid      = valid_ff[N-1];
   assign rsp_data.x_out = stage_ff[N-1].x_raw;
   assign rsp_data.y_out = stage_ff[N-1].y_raw;

endmodule

// ----- rtl/rsd_checker.sv -----
// Port-level assertions for the stick deadzone core, bound to the top level.
module rsd_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input rsd_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rsd_pkg::rsp_type rsp_data,
   input logic             csr_ready
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // a free output side, or an empty output stage, means input is taken
   a_ready_path: assert property (@(posedge clock) disable iff (reset)
      (rsp_ready || !rsp_valid) |-> req_ready)
      else $error("input blocked with room in the pipeline");

   // nothing comes out in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word right after reset");

   // a waiting input word stays put
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("input word changed while waiting");

   // register port never pushes back
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("csr port not ready");

endmodule

bind radial_stick_deadzone_core rsd_checker u_rsd_checker (.*);

// ----- verif/tb.sv -----
// Testbench for the radial stick deadzone core: directed and random stick words checked in order.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned LATENCY   = 75;
   localparam int unsigned N_RANDOM  = 1650;
   localparam longint      CYCLE_CAP = 2000000;

   typedef enum int {MODE_NONE, MODE_SENDER, MODE_RECEIVER, MODE_BOTH} idle_mode_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   rsd_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   rsd_pkg::rsp_type rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [rsd_pkg::PCT_W-1:0] csr_data;

   radial_stick_deadzone_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   rsd_pkg::req_type pending_words[$];
   rsd_pkg::rsp_type expected_words[$];
   int unsigned   active_pct;
   idle_mode_type idle_mode;
   int unsigned   hold_off;
   longint        cycle_count;
   int            error_count;
   int            checked_count;
   int            pct_settings;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned isqrt(int unsigned v);
      int unsigned r;
      r = 0;
      while ((r + 1) * (r + 1) <= v) r++;
      return r;
   endfunction

   function automatic longint round_div(longint num, longint den);
      if (num >= 0) return (num + den / 2) / den;
      return -((-num + den / 2) / den);
   endfunction

   function automatic longint sat_byte(longint v);
      if (v < -128) return -128;
      if (v > 127) return 127;
      return v;
   endfunction

   function automatic bit sender_idles();
      if (idle_mode == MODE_SENDER) return $urandom_range(99) < 74;
      if (idle_mode == MODE_BOTH) return $urandom_range(99) < 6;
      return 1'b0;
   endfunction

   // deadzone mapping for one stick word at the given percent
   function automatic rsd_pkg::rsp_type deadzone_map(rsd_pkg::req_type w, int unsigned pct);
      rsd_pkg::rsp_type r;
      longint dx, dy, ax, ay, rx, ry;
      longint mag, dz, maxm, c, omag;
      r.x_out = 8'(rsd_pkg::CENTER);
      r.y_out = 8'(rsd_pkg::CENTER);
      if (pct == 0) begin
         r.x_out = w.x_raw;
         r.y_out = w.y_raw;
         return r;
      end
      dx  = longint'(w.x_raw) - 128;
      dy  = longint'(w.y_raw) - 128;
      ax  = dx < 0 ? -dx : dx;
      ay  = dy < 0 ? -dy : dy;
      mag = isqrt(int'(dx * dx + dy * dy));
      dz  = (pct * 128 + 50) / 100;
      if (mag == 0 || mag <= dz) return r;
      maxm = 64'hFFFFFFFF;
      if (ax != 0) maxm = mag * (dx < 0 ? rsd_pkg::NEG_LIMIT : rsd_pkg::POS_LIMIT) / ax;
      if (ay != 0) begin
         c = mag * (dy < 0 ? rsd_pkg::NEG_LIMIT : rsd_pkg::POS_LIMIT) / ay;
         if (c < maxm) maxm = c;
      end
      if (maxm <= dz) return r;
      omag = ((mag - dz) * maxm) / (maxm - dz);
      rx = sat_byte(round_div(dx * omag, mag));
      ry = sat_byte(round_div(dy * omag, mag));
      r.x_out = 8'(rx + 128);
      r.y_out = 8'(ry + 128);
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) expected_words.push_back(deadzone_map(req_data, active_pct));
         if (pending_words.size() != 0 && !sender_idles()) begin
            req_valid <= 1'b1;
            req_data  <= pending_words.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off countdown
   always @(posedge clock) begin
      if (hold_off != 0) hold_off <= hold_off - 1;
   end

   // receiver stall and monitor
   always @(posedge clock) begin
      rsd_pkg::rsp_type exp_w;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word x=%0d y=%0d", $time, rsp_data.x_out,
                        rsp_data.y_out);
               error_count++;
            end else begin
               exp_w = expected_words.pop_front();
               checked_count++;
               if (exp_w.x_out !== rsp_data.x_out)
                  $display("%0t: x_out expected %0d got %0d", $time, exp_w.x_out,
                           rsp_data.x_out);
               if (exp_w.y_out !== rsp_data.y_out)
                  $display("%0t: y_out expected %0d got %0d", $time, exp_w.y_out,
                           rsp_data.y_out);
               if (exp_w !== rsp_data) error_count++;
            end
         end
         if (hold_off != 0) begin
            rsp_ready <= 1'b0;
         end else if (idle_mode == MODE_RECEIVER) begin
            rsp_ready <= $urandom_range(99) >= 74;
         end else if (idle_mode == MODE_BOTH) begin
            rsp_ready <= $urandom_range(99) >= 6;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_words.size() != 0 || req_valid || expected_words.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_pct(logic [rsd_pkg::PCT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid  <= 1'b0;
      active_pct = value > rsd_pkg::PCT_MAX ? rsd_pkg::PCT_MAX : value;
      pct_settings++;
   endtask

   task automatic queue_random(int n);
      rsd_pkg::req_type w;
      int unsigned r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(9);
         w.x_raw = 8'($urandom);
         w.y_raw = 8'($urandom);
         // bias toward the center region and the square edge
         if (r < 3) begin
            w.x_raw = 8'(128 + int'($urandom_range(80)) - 40);
            w.y_raw = 8'(128 + int'($urandom_range(80)) - 40);
         end else if (r < 5) begin
            w.x_raw = $urandom_range(1) ? 8'd255 - 8'($urandom_range(3))
                                        : 8'($urandom_range(3));
         end
         pending_words.push_back(w);
      end
   endtask

   initial begin
      automatic logic [4:0] pct_list[8] = '{5'd0, 5'd1, 5'd30, 5'd31, 5'd10, 5'd17,
                                            5'd25, 5'd0};
      automatic logic [7:0] edges[6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd255};
      rsd_pkg::req_type w;
      rsd_pkg::req_type held_words[$];
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_ready   = 1'b0;
      csr_valid   = 1'b0;
      csr_data    = '0;
      active_pct  = 0;
      idle_mode   = MODE_NONE;
      hold_off    = 0;
      cycle_count = 0;
      error_count = 0;
      checked_count = 0;
      pct_settings  = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: axis and diagonal edge values at no deadzone, then at the largest one
      for (int p = 0; p < 2; p++) begin
         if (p == 1) write_pct(5'd31);
         for (int i = 0; i < 6; i++) begin
            for (int j = 0; j < 2; j++) begin
               w.x_raw = edges[i];
               w.y_raw = j ? edges[5 - i] : 8'd128;
               pending_words.push_back(w);
            end
         end
         wait_drained();
      end

      for (int s = 0; s < 8; s++) begin
         write_pct(pct_list[s]);
         idle_mode = idle_mode_type'(s % 4);
         queue_random(N_RANDOM / 8);
         if (s == 2) begin
            // long receiver hold-off while words keep coming
            @(posedge clock);
            hold_off <= 300;
         end
         if (s == 5) begin
            // sender pause until all words are back
            while (pending_words.size() > N_RANDOM / 16) @(posedge clock);
            held_words = pending_words;
            pending_words.delete();
            while (req_valid || expected_words.size() != 0) @(posedge clock);
            pending_words = held_words;
         end
         wait_drained();
      end

      $display("covered %0d result words over %0d deadzone settings, all idle modes",
               checked_count, pct_settings);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", error_count);
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

// ----- radial_stick_deadzone_core.f -----
rtl/rsd_pkg.sv
rtl/radial_stick_deadzone_core.sv
rtl/rsd_checker.sv
verif/tb.sv
